>>> rtl/core/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg - shared types and constants for the bitmap priority run queue
// Sizes, operation codes, word layouts and the controller/datapath links.
// ----------------------------------------------------------------------------
package brq_pkg;

  // Queue dimensions
  localparam int LEVELS  = 32;
  localparam int THREADS = 64;
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int TID_W   = $clog2(THREADS);
  localparam int CNT_W   = $clog2(THREADS + 1);

  // Fixed field widths of the stream words
  localparam int F_TID_W  = 6;
  localparam int F_PRIO_W = 5;
  localparam int F_QNT_W  = 16;
  localparam int F_CNT_W  = 7;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;

  localparam logic [F_QNT_W-1:0] TIME_SLICE_RST = 16'd4000;

  // Operation codes (travel in in_tuser)
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_RESCHED = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_in;       // latch the input word and the old running thread
    logic set_err;       // refuse the insert
    logic push_ins;      // set up a push of the inserted thread
    logic push_requeue;  // set up a push of the running thread
    logic count_dec;     // drop a blocked thread from the count
    logic push_wr;       // link the pushed thread into its level
    logic pop_sel;       // pick the highest nonempty level
    logic pop_take;      // take the head of the picked level
    logic pop_link;      // advance the head to its successor
    logic out_load;      // fill the output register
  } brq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic runnable;
    logic dup;
    logic idle;
    logic bitmap_empty;
    logic head_eq_tail;
    logic out_free;
  } brq_sts_t;

endpackage

>>> rtl/core/brq_ctrl.sv
// ----------------------------------------------------------------------------
// brq_ctrl - sequencer of the run queue
// Steps each word through insert, requeue and pick phases of the datapath.
// ----------------------------------------------------------------------------
module brq_ctrl
  import brq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  brq_sts_t sts,
  output brq_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_LVL      = 4'd2;
  localparam logic [3:0] ST_PUSH_RD  = 4'd3;
  localparam logic [3:0] ST_PUSH_WR  = 4'd4;
  localparam logic [3:0] ST_POP_SEL  = 4'd5;
  localparam logic [3:0] ST_POP_RD   = 4'd6;
  localparam logic [3:0] ST_POP_CMP  = 4'd7;
  localparam logic [3:0] ST_POP_LINK = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_insert) begin
          if (sts.dup) begin
            cmd.set_err = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            cmd.push_ins = 1'b1;
            state_nxt    = ST_PUSH_RD;
          end
        end else if (!sts.idle && sts.runnable) begin
          state_nxt = ST_LVL;
        end else begin
          cmd.count_dec = !sts.idle;
          state_nxt     = ST_POP_SEL;
        end
      end
      ST_LVL: begin
        cmd.push_requeue = 1'b1;
        state_nxt        = ST_PUSH_RD;
      end
      ST_PUSH_RD: state_nxt = ST_PUSH_WR;
      ST_PUSH_WR: begin
        cmd.push_wr = 1'b1;
        state_nxt   = sts.is_insert ? ST_DONE : ST_POP_SEL;
      end
      ST_POP_SEL: begin
        cmd.pop_sel = 1'b1;
        state_nxt   = sts.bitmap_empty ? ST_DONE : ST_POP_RD;
      end
      ST_POP_RD: state_nxt = ST_POP_CMP;
      ST_POP_CMP: begin
        cmd.pop_take = 1'b1;
        state_nxt    = sts.head_eq_tail ? ST_DONE : ST_POP_LINK;
      end
      ST_POP_LINK: begin
        cmd.pop_link = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/brq_dp.sv
// ----------------------------------------------------------------------------
// brq_dp - run queue datapath
// Level bitmap, head/tail/link/level memories, running thread, count,
// time slice register and the output word register.
// ----------------------------------------------------------------------------
module brq_dp
  import brq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [IN_W-1:0]    in_tdata,
  input  logic [0:0]         in_tuser,
  input  logic               cfg_valid,
  input  logic [F_QNT_W-1:0] cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,
  input  brq_cmd_t           cmd,
  output brq_sts_t           sts
);

  // Latched input word
  logic                op_r;
  logic [F_TID_W-1:0]  tid_in_r;
  logic [F_PRIO_W-1:0] prio_in_r;
  logic                runnable_r;
  logic [TID_W-1:0]    old_thread_r;
  logic                old_idle_r;
  logic                err_r;

  // Scheduler state
  logic [LEVELS-1:0]   bitmap_r;
  logic [THREADS-1:0]  present_r;
  logic [TID_W-1:0]    running_r;
  logic                idle_r;
  logic [CNT_W-1:0]    count_r;
  logic [F_QNT_W-1:0]  slice_r;

  // Working registers
  logic [LVL_W-1:0]    lvl_r;
  logic [TID_W-1:0]    push_tid_r;

  // Memories and their registered read data
  logic [TID_W-1:0] head_mem [LEVELS];
  logic [TID_W-1:0] tail_mem [LEVELS];
  logic [TID_W-1:0] link_mem [THREADS];
  logic [LVL_W-1:0] lvl_mem  [THREADS];
  logic [TID_W-1:0] head_q, tail_q, link_q;
  logic [LVL_W-1:0] lvl_q;

  // Output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [LVL_W-1:0] ins_lvl;
  logic [LVL_W-1:0] top_lvl;
  logic             dup;
  logic             switched;

  // Saturate the requested level
  always_comb begin
    if (int'(prio_in_r) >= LEVELS) begin
      ins_lvl = LVL_W'(LEVELS - 1);
    end else begin
      ins_lvl = LVL_W'(prio_in_r);
    end
  end

  // Refuse ids out of range, queued threads and the running thread
  always_comb begin
    dup = 1'b0;
    if (int'(tid_in_r) >= THREADS) begin
      dup = 1'b1;
    end else if (present_r[TID_W'(tid_in_r)]) begin
      dup = 1'b1;
    end else if (!idle_r && (running_r == TID_W'(tid_in_r))) begin
      dup = 1'b1;
    end
  end

  // Highest nonempty level
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bitmap_r[i]) top_lvl = LVL_W'(i);
    end
  end

  assign switched = (old_idle_r != idle_r) || (!idle_r && (old_thread_r != running_r));

  assign sts.is_insert    = (op_r == OP_INSERT);
  assign sts.runnable     = runnable_r;
  assign sts.dup          = dup;
  assign sts.idle         = idle_r;
  assign sts.bitmap_empty = (bitmap_r == '0);
  assign sts.head_eq_tail = (head_q == tail_q);
  assign sts.out_free     = !out_valid_r || out_tready;

  // Memory reads, one registered port each
  always_ff @(posedge clk) begin
    head_q <= head_mem[lvl_r];
    tail_q <= tail_mem[lvl_r];
    link_q <= link_mem[head_q];
    lvl_q  <= lvl_mem[running_r];
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      if (bitmap_r[lvl_r]) begin
        link_mem[tail_q] <= push_tid_r;
      end else begin
        head_mem[lvl_r] <= push_tid_r;
      end
      tail_mem[lvl_r]    <= push_tid_r;
      lvl_mem[push_tid_r] <= lvl_r;
    end else if (cmd.pop_link) begin
      head_mem[lvl_r] <= link_q;
    end
  end

  // Payload registers of the current word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r         <= in_tuser[0];
      tid_in_r     <= in_tdata[F_TID_W-1:0];
      prio_in_r    <= in_tdata[F_TID_W +: F_PRIO_W];
      runnable_r   <= in_tdata[F_TID_W + F_PRIO_W];
      old_thread_r <= running_r;
      old_idle_r   <= idle_r;
    end
    if (cmd.push_ins) begin
      lvl_r      <= ins_lvl;
      push_tid_r <= TID_W'(tid_in_r);
    end else if (cmd.push_requeue) begin
      lvl_r      <= lvl_q;
      push_tid_r <= running_r;
    end else if (cmd.pop_sel) begin
      lvl_r <= top_lvl;
    end
  end

  // Scheduler control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_r  <= '0;
      present_r <= '0;
      running_r <= '0;
      idle_r    <= 1'b1;
      count_r   <= '0;
      slice_r   <= TIME_SLICE_RST;
      err_r     <= 1'b0;
    end else begin
      if (cfg_valid) slice_r <= cfg_data;
      if (cmd.load_in) err_r <= 1'b0;
      if (cmd.set_err) err_r <= 1'b1;
      if (cmd.push_ins) count_r <= count_r + CNT_W'(1);
      if (cmd.count_dec && (count_r != '0)) count_r <= count_r - CNT_W'(1);
      if (cmd.push_wr) begin
        bitmap_r[lvl_r]       <= 1'b1;
        present_r[push_tid_r] <= 1'b1;
      end
      if (cmd.pop_sel && (bitmap_r == '0)) idle_r <= 1'b1;
      if (cmd.pop_take) begin
        present_r[head_q] <= 1'b0;
        running_r         <= head_q;
        idle_r            <= 1'b0;
        if (head_q == tail_q) bitmap_r[lvl_r] <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {err_r,
                     switched,
                     F_CNT_W'(count_r),
                     idle_r ? F_QNT_W'(0) : slice_r,
                     idle_r,
                     idle_r ? F_TID_W'(0) : F_TID_W'(running_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/core/bitmap_priority_run_queue.sv
// ----------------------------------------------------------------------------
// bitmap_priority_run_queue - priority run queue with a level bitmap
// One FIFO per priority level linked through per-thread pointers; insert
// appends a thread, reschedule requeues the running thread if it is
// runnable and picks the head of the highest nonempty level.
// ----------------------------------------------------------------------------
//  channel | dir | word                                   | handshake
//  in_     | in  | tdata 16b, tuser = opcode              | in_tvalid/in_tready
//  out_    | out | tdata 32b, one word per input word     | out_tvalid/out_tready
//  cfg_    | in  | cfg_data = time_slice                  | cfg_valid/cfg_ready
//
//  Insert and reschedule step through the controller states in turn: the
//  head, tail, link and level memories are read and written in turn, one
//  registered port each. One word is in flight at a time.
//  The next word is taken while the result waits in the output register.
//  Synchronous active-low reset; time_slice resets to 4000, idle runs.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module bitmap_priority_run_queue
  import brq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [5:0] thread_id, [10:6] priority_req, [11] current_runnable, [15:12] zero
  input  logic [IN_W-1:0]    in_tdata,
  // [0] opcode
  input  logic [0:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [5:0] current_thread, [6] current_is_idle, [22:7] quantum,
  // [29:23] thread_count, [30] switched, [31] insert_error
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [F_QNT_W-1:0] cfg_data
);

  brq_cmd_t cmd;
  brq_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer
  brq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queue storage and result word
  brq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
